>>> design/clipped_rect_fill_rgb565_assert.svh
// Assertion macros for the checker file.
`ifndef CLIPPED_RECT_FILL_RGB565_ASSERT_SVH
`define CLIPPED_RECT_FILL_RGB565_ASSERT_SVH

// Clocked assertion, disabled while reset is applied.
`define CRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that also checks across reset.
`define CRF_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> design/crf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package crf_pkg;

    localparam int FRAME_WIDTH  = 128;
    localparam int FRAME_HEIGHT = 128;

    localparam int COORD_W  = 7;
    localparam int ADDR_W   = 14;
    localparam int WORD_W   = 16;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 48;

    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(FRAME_WIDTH - 1);
    localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(FRAME_HEIGHT - 1);

    typedef enum logic {
        KIND_RECT = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    // Decoded rectangle command, ready to load into the raster state.
    typedef struct packed {
        logic                   in_frame;
        logic [COORD_W-1:0]     start_col;
        logic [COORD_W-1:0]     end_col;
        logic [COORD_W-1:0]     start_row;
        logic [COORD_W-1:0]     end_row;
        logic [WORD_W-1:0]      fill_word;
    } rect_cmd_t;

endpackage
`default_nettype wire

>>> design/clipped_rect_fill_rgb565.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Carries
// s_*       in         rectangle command (tuser 0) or pixel tick (tuser 1)
// m_*       out        one frame-buffer write per tick while a rectangle is open
//
// One item per cycle unless m_tready stalls: an input register feeds span
// clipping, color scaling and the raster counters, which load the result
// register in the same cycle; a tick's write leaves on m_* from that register.
// Reset clears the handshake registers and the raster state; the block is idle.
// A stall on m_tready holds the result register, then the input register.
module clipped_rect_fill_rgb565 (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // origin_x[7:0], origin_y[15:8], extent_w[24:16], extent_h[33:25],
    // color_rgb[57:34], zero fill above
    input  wire logic [crf_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // pixel_address[13:0], pixel_column[20:14], pixel_row[27:21],
    // pixel_word[43:28], zero fill above
    output logic [crf_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tlast
);

    logic                           in_valid_reg;
    logic                           in_kind_reg;
    logic [57:0]                    in_data_reg;
    logic                           advance;
    crf_pkg::rect_cmd_t             cmd;
    logic [7:0]                     origin_x;
    logic [7:0]                     origin_y;

    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[57:0];
        end
    end

    assign origin_x = in_data_reg[7:0];
    assign origin_y = in_data_reg[15:8];

    assign cmd.in_frame = (9'(origin_x) <= 9'(crf_pkg::LAST_COL))
                       && (9'(origin_y) <= 9'(crf_pkg::LAST_ROW));

    crf_span u_span_x (
        .anchor (origin_x),
        .extent (signed'(in_data_reg[24:16])),
        .limit  (crf_pkg::LAST_COL),
        .lo     (cmd.start_col),
        .hi     (cmd.end_col)
    );

    crf_span u_span_y (
        .anchor (origin_y),
        .extent (signed'(in_data_reg[33:25])),
        .limit  (crf_pkg::LAST_ROW),
        .lo     (cmd.start_row),
        .hi     (cmd.end_row)
    );

    crf_color u_color (
        .color_rgb (in_data_reg[57:34]),
        .fill_word (cmd.fill_word)
    );

    crf_raster u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_kind  (in_kind_reg),
        .cmd        (cmd),
        .out_ready  (m_tready),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
`default_nettype wire

>>> design/crf_span.sv
`timescale 1ns / 1ps
`default_nettype none
module crf_span (
    input  wire logic [7:0]                     anchor,
    input  wire logic signed [8:0]              extent,
    input  wire logic [crf_pkg::COORD_W-1:0]    limit,
    output logic [crf_pkg::COORD_W-1:0]         lo,
    output logic [crf_pkg::COORD_W-1:0]         hi
);

    logic signed [10:0] anchor_s;
    logic signed [10:0] extent_s;
    logic signed [10:0] start_s;
    logic signed [10:0] end_s;
    logic signed [10:0] limit_s;

    assign anchor_s = signed'({3'b000, anchor});
    assign extent_s = 11'(extent);
    assign limit_s  = signed'({4'b0000, limit});

    // Inclusive span: a negative extent reaches back from the anchor.
    assign start_s = extent[8] ? (anchor_s + extent_s) : anchor_s;
    assign end_s   = extent[8] ? anchor_s : (anchor_s + extent_s);

    assign lo = start_s[10] ? '0 : start_s[crf_pkg::COORD_W-1:0];
    assign hi = (end_s > limit_s) ? limit : end_s[crf_pkg::COORD_W-1:0];

endmodule
`default_nettype wire

>>> design/crf_color.sv
`timescale 1ns / 1ps
`default_nettype none
module crf_color (
    input  wire logic [23:0]                    color_rgb,
    output logic [crf_pkg::WORD_W-1:0]          fill_word
);

    logic [13:0] r_prod;
    logic [13:0] g_prod;
    logic [13:0] b_prod;
    logic [13:0] r_q;
    logic [13:0] g_q;
    logic [13:0] b_q;

    // c*31 and c*63 as shift and subtract
    assign r_prod = {1'b0, color_rgb[23:16], 5'b0} - {6'b0, color_rgb[23:16]};
    assign g_prod = {color_rgb[15:8], 6'b0} - {6'b0, color_rgb[15:8]};
    assign b_prod = {1'b0, color_rgb[7:0], 5'b0} - {6'b0, color_rgb[7:0]};

    // x/255 for the 14-bit products x: (x + 1 + x/256) / 256
    assign r_q = (r_prod + 14'd1 + {8'b0, r_prod[13:8]}) >> 8;
    assign g_q = (g_prod + 14'd1 + {8'b0, g_prod[13:8]}) >> 8;
    assign b_q = (b_prod + 14'd1 + {8'b0, b_prod[13:8]}) >> 8;

    // byte-swapped RGB565
    assign fill_word = {g_q[2:0], b_q[4:0], r_q[4:0], g_q[5:3]};

endmodule
`default_nettype wire

>>> design/crf_raster.sv
`timescale 1ns / 1ps
`default_nettype none
module crf_raster (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           item_valid,
    input  wire logic                           item_kind,
    input  wire crf_pkg::rect_cmd_t             cmd,
    input  wire logic                           out_ready,
    output logic                                advance,
    output logic                                out_valid,
    output logic [crf_pkg::M_DATA_W-1:0]        out_data,
    output logic                                out_last
);

    localparam int CW = crf_pkg::COORD_W;

    logic                       active_reg, active_next;
    logic [CW-1:0]              cur_col_reg, cur_col_next;
    logic [CW-1:0]              cur_row_reg, cur_row_next;
    logic [CW-1:0]              start_col_reg, start_col_next;
    logic [CW-1:0]              end_col_reg, end_col_next;
    logic [CW-1:0]              end_row_reg, end_row_next;
    logic [crf_pkg::WORD_W-1:0] fill_word_reg, fill_word_next;
    logic                       out_valid_reg, out_valid_next;
    logic [crf_pkg::M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                       out_last_reg, out_last_next;

    logic                       fire;
    logic                       emit;
    logic                       row_done;
    logic                       fin;
    logic [crf_pkg::ADDR_W-1:0] pix_addr;

    // advance when the result register is empty or its transaction leaves now
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = item_valid && advance;
    assign emit     = fire && (item_kind == crf_pkg::KIND_TICK) && active_reg;
    assign row_done = (cur_col_reg == end_col_reg);
    assign fin      = row_done && (cur_row_reg == end_row_reg);
    assign pix_addr = crf_pkg::ADDR_W'(int'(cur_row_reg) * crf_pkg::FRAME_WIDTH
                                       + int'(cur_col_reg));

    always_comb begin
        active_next    = active_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        start_col_next = start_col_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        fill_word_next = fill_word_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (advance) begin
            out_valid_next = emit;
        end

        if (fire && (item_kind == crf_pkg::KIND_RECT)) begin
            // an anchor outside the frame drops any rectangle in progress
            active_next = cmd.in_frame;
            if (cmd.in_frame) begin
                start_col_next = cmd.start_col;
                end_col_next   = cmd.end_col;
                cur_col_next   = cmd.start_col;
                cur_row_next   = cmd.start_row;
                end_row_next   = cmd.end_row;
                fill_word_next = cmd.fill_word;
            end
        end else if (emit) begin
            out_data_next = {{(crf_pkg::M_DATA_W - crf_pkg::WORD_W - 2*CW
                               - crf_pkg::ADDR_W){1'b0}},
                             fill_word_reg, cur_row_reg, cur_col_reg, pix_addr};
            out_last_next = fin;
            if (fin) begin
                active_next = 1'b0;
            end else if (row_done) begin
                cur_col_next = start_col_reg;
                cur_row_next = cur_row_reg + CW'(1);
            end else begin
                cur_col_next = cur_col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            start_col_reg <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            fill_word_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            start_col_reg <= start_col_next;
            end_col_reg   <= end_col_next;
            end_row_reg   <= end_row_next;
            fill_word_reg <= fill_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

>>> design/crf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "clipped_rect_fill_rgb565_assert.svh"
module crf_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [crf_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [crf_pkg::M_DATA_W-1:0]   m_tdata,
    input  wire logic                           m_tlast
);

    logic [crf_pkg::ADDR_W-1:0] exp_addr;

    assign exp_addr = crf_pkg::ADDR_W'(int'(m_tdata[27:21]) * crf_pkg::FRAME_WIDTH
                                       + int'(m_tdata[20:14]));

    // a stalled write transaction holds its contents
    `CRF_ASSERT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled m transaction changed")

    // reset leaves no write pending
    `CRF_ASSERT_RST(a_rst_idle, aclk, !aresetn |=> !m_tvalid, "m_tvalid set after reset")

    // a write starting from idle comes from a tick that passed through the input and result registers
    `CRF_ASSERT(a_tick_src, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser, 2), "write without a preceding tick")

    // address agrees with row and column, and the fill bits above are zero
    `CRF_ASSERT(a_addr, aclk, aresetn, m_tvalid |-> (m_tdata[13:0] == exp_addr) && (m_tdata[47:44] == 4'b0000), "bad pixel address or fill bits")

endmodule

bind clipped_rect_fill_rgb565 crf_checker u_crf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire
